// File: rtl/core/rope_pkg.sv
package rope_pkg;

	// data widths
	localparam int DW = 32;                // Q16.16 element
	localparam int CW = 34;                // CORDIC datapath, Q30 with guard bits
	localparam int EW = 12;                // element index (2 * pair index)

	// configuration register indexes
	localparam logic [1:0] REG_HEAD_SIZE = 2'd0;
	localparam logic [1:0] REG_KV_DIM    = 2'd1;

	localparam logic [9:0]  HEAD_SIZE_RST = 10'd128;
	localparam logic [12:0] KV_DIM_RST    = 13'd4096;

	// fixed-point constants
	localparam logic [31:0] LOG2_1E4_Q28 = 32'd3566893132;
	localparam logic [31:0] LN2_Q32      = 32'd2977044472;
	localparam logic [29:0] INV2PI_Q32   = 30'd683565276;
	localparam int          TAYLOR_TERMS = 12;

	localparam logic signed [CW-1:0] CORDIC_K_Q30 = CW'(64'sd652032874);
	localparam logic signed [CW-1:0] QUARTER_TURN = CW'(64'sd1073741824);
	localparam logic signed [CW-1:0] HALF_TURN    = CW'(64'sd2147483648);

	typedef struct packed {
		logic [15:0]          position;
		logic [10:0]          pair_index;
		logic signed [DW-1:0] q_even;
		logic signed [DW-1:0] q_odd;
		logic signed [DW-1:0] k_even;
		logic signed [DW-1:0] k_odd;
	} rope_in_t;

	typedef struct packed {
		logic signed [DW-1:0] q_even_out;
		logic signed [DW-1:0] q_odd_out;
		logic signed [DW-1:0] k_even_out;
		logic signed [DW-1:0] k_odd_out;
		logic                 key_rotated;
	} rope_out_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [12:0] value;
	} rope_cfg_t;

	// per-item data that rides along with the angle computation
	typedef struct packed {
		logic                 bypass;
		logic                 rot_k;
		logic signed [DW-1:0] q_even;
		logic signed [DW-1:0] q_odd;
		logic signed [DW-1:0] k_even;
		logic signed [DW-1:0] k_odd;
	} rope_side_t;

	// arctangent of 2^-i in Q32 turns
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] a;
		case (i)
			5'd0:  a = 32'h20000000;
			5'd1:  a = 32'h12E4051E;
			5'd2:  a = 32'h09FB385B;
			5'd3:  a = 32'h051111D4;
			5'd4:  a = 32'h028B0D43;
			5'd5:  a = 32'h0145D7E1;
			5'd6:  a = 32'h00A2F61E;
			5'd7:  a = 32'h00517C55;
			5'd8:  a = 32'h0028BE53;
			5'd9:  a = 32'h00145F2F;
			5'd10: a = 32'h000A2F98;
			5'd11: a = 32'h000517CC;
			5'd12: a = 32'h00028BE6;
			5'd13: a = 32'h000145F3;
			5'd14: a = 32'h0000A2FA;
			5'd15: a = 32'h0000517D;
			5'd16: a = 32'h000028BE;
			5'd17: a = 32'h0000145F;
			5'd18: a = 32'h00000A30;
			5'd19: a = 32'h00000518;
			5'd20: a = 32'h0000028C;
			5'd21: a = 32'h00000146;
			5'd22: a = 32'h000000A3;
			5'd23: a = 32'h00000051;
			5'd24: a = 32'h00000029;
			5'd25: a = 32'h00000014;
			5'd26: a = 32'h0000000A;
			5'd27: a = 32'h00000005;
			5'd28: a = 32'h00000003;
			5'd29: a = 32'h00000001;
			5'd30: a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

endpackage

// File: rtl/core/rope_if.sv
interface rope_in_if;
	import rope_pkg::*;
	logic     valid;
	logic     ready;
	rope_in_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rope_out_if;
	import rope_pkg::*;
	logic      valid;
	logic      ready;
	rope_out_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rope_cfg_if;
	import rope_pkg::*;
	logic      valid;
	logic      ready;
	rope_cfg_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/core/rope_freq.sv
module rope_freq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 v_in,
	input  logic [15:0]          position,
	input  logic [11:0]          elem,
	input  logic [9:0]           head_len,
	input  rope_pkg::rope_side_t side_in,
	output logic                 v_out,
	output logic [31:0]          phase,
	output rope_pkg::rope_side_t side_out
);
	import rope_pkg::*;

	// stage map
	localparam int DIV_PER = 4;
	localparam int DIV_ST  = (EW + 24) / DIV_PER;
	localparam int TAY_ST  = 3 * (TAYLOR_TERMS - 1);
	localparam int M1      = DIV_ST;
	localparam int M2      = DIV_ST + 1;
	localparam int TAY0    = DIV_ST + 2;
	localparam int F1      = TAY0 + TAY_ST;
	localparam int F2      = F1 + 1;
	localparam int F3      = F1 + 2;
	localparam int NST     = F3 + 1;

	typedef struct packed {
		logic [15:0] position;
		rope_side_t  side;
	} ctx_t;

	typedef struct packed {
		logic [EW-1:0] dvd;
		logic [9:0]    rem;
		logic [23:0]   quo;
	} div_t;

	typedef struct packed {
		logic [31:0]        x;
		logic [31:0]        term;
		logic [31:0]        p;
		logic [63:0]        m;
		logic signed [34:0] sum;
		logic [3:0]         n;
	} tay_t;

	// restoring division steps, one dividend bit each
	function automatic div_t div_step(input div_t d, input logic [9:0] hs);
		div_t        r;
		logic [10:0] sh;
		logic        qb;
		r = d;
		for (int i = 0; i < DIV_PER; i++) begin
			sh = {r.rem, r.dvd[EW-1]};
			r.dvd = {r.dvd[EW-2:0], 1'b0};
			qb = 1'b0;
			if (sh >= {1'b0, hs}) begin
				sh = sh - {1'b0, hs};
				qb = 1'b1;
			end
			r.rem = sh[9:0];
			r.quo = {r.quo[22:0], qb};
		end
		return r;
	endfunction

	logic v_s   [NST];
	ctx_t ctx_s [NST];
	logic v_d   [NST];
	ctx_t ctx_d [NST];

	// valid and side data chain
	assign v_d[0]   = v_in;
	assign ctx_d[0] = '{position: position, side: side_in};
	for (genvar g = 0; g < NST; g++) begin : g_chain
		if (g > 0) begin : g_link
			assign v_d[g]   = v_s[g-1];
			assign ctx_d[g] = ctx_s[g-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= v_d[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[g] <= ctx_d[g];
			end
		end
	end

	// dim = elem mod head length, ratio = (dim << 24) / head length
	div_t div_s [DIV_ST];
	for (genvar g = 0; g < DIV_ST; g++) begin : g_div
		div_t d_in;
		if (g == 0) begin : g_src
			assign d_in = '{dvd: elem, rem: '0, quo: '0};
		end else begin : g_prev
			assign d_in = div_s[g-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[g] <= div_step(d_in, head_len);
			end
		end
	end

	// t = ratio * log2(10000)
	logic [23:0] ratio;
	logic [55:0] t_prod;
	logic [31:0] t_s;
	assign ratio  = (head_len == '0) ? '0 : div_s[DIV_ST-1].quo;
	assign t_prod = 56'(ratio) * 56'(LOG2_1E4_Q28);
	always_ff @(posedge clk) begin
		if (en) begin
			t_s <= t_prod[55:24];
		end
	end

	// x = frac(t) * ln2, first Taylor term
	logic [59:0] x_prod;
	logic [31:0] x_val;
	tay_t        m2_s;
	assign x_prod = 60'(t_s[27:0]) * 60'(LN2_Q32);
	assign x_val  = x_prod[59:28];
	always_ff @(posedge clk) begin
		if (en) begin
			m2_s <= '{x: x_val, term: x_val, p: '0, m: '0,
				sum: 35'sd4294967296 - $signed({3'b000, x_val}), n: t_s[31:28]};
		end
	end

	// Taylor terms 2..12: product, reciprocal multiply, correction
	tay_t tay_s [TAY_ST];
	for (genvar s = 0; s < TAY_ST; s++) begin : g_tay
		localparam int          K     = s / 3 + 2;
		localparam int          PH    = s % 3;
		localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);
		tay_t tin;
		tay_t tnx;
		if (s == 0) begin : g_src
			assign tin = m2_s;
		end else begin : g_prev
			assign tin = tay_s[s-1];
		end
		if (PH == 0) begin : g_mul
			logic [63:0] pf;
			assign pf = 64'(tin.term) * 64'(tin.x);
			always_comb begin
				tnx   = tin;
				tnx.p = pf[63:32];
			end
		end else if (PH == 1) begin : g_rcp
			always_comb begin
				tnx   = tin;
				tnx.m = 64'(tin.p) * 64'(RECIP);
			end
		end else begin : g_fix
			logic [31:0] q0;
			logic [35:0] rem;
			assign q0  = tin.m[63:32];
			assign rem = 36'(tin.p) - 36'(q0) * 36'(K);
			always_comb begin
				tnx      = tin;
				tnx.term = (rem >= 36'(K)) ? q0 + 32'd1 : q0;
				if ((K % 2) == 1) begin
					tnx.sum = tin.sum - $signed({3'b000, tnx.term});
				end else begin
					tnx.sum = tin.sum + $signed({3'b000, tnx.term});
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				tay_s[s] <= tnx;
			end
		end
	end

	// freq = exp(-x) >> n
	tay_t        tay_last;
	logic [32:0] e_val;
	logic [32:0] freq_s;
	assign tay_last = tay_s[TAY_ST-1];
	assign e_val    = tay_last.sum[34] ? '0 : tay_last.sum[32:0];
	always_ff @(posedge clk) begin
		if (en) begin
			freq_s <= e_val >> tay_last.n;
		end
	end

	// frequency in turns
	logic [62:0] ft_prod;
	logic [46:0] ft_s;
	assign ft_prod = 63'(freq_s) * 63'(INV2PI_Q32);
	always_ff @(posedge clk) begin
		if (en) begin
			ft_s <= ft_prod[62:16];
		end
	end

	// phase = position * freq, wrapped to one turn
	logic [62:0] ph_prod;
	logic [31:0] phase_s;
	assign ph_prod = 63'(ctx_s[F2].position) * 63'(ft_s);
	always_ff @(posedge clk) begin
		if (en) begin
			phase_s <= ph_prod[47:16];
		end
	end

	assign v_out    = v_s[NST-1];
	assign side_out = ctx_s[NST-1].side;
	assign phase    = phase_s;

endmodule

// File: rtl/core/rope_cordic.sv
module rope_cordic #(
	parameter int CORDIC_STAGES = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           v_in,
	input  logic [31:0]                    phase,
	input  rope_pkg::rope_side_t           side_in,
	output logic                           v_out,
	output logic signed [rope_pkg::CW-1:0] cos_val,
	output logic signed [rope_pkg::CW-1:0] sin_val,
	output rope_pkg::rope_side_t           side_out
);
	import rope_pkg::*;

	localparam int NIT    = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
	localparam int IT_ST  = (NIT + 1) / 2;
	localparam int NST    = IT_ST + 2;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 neg;
	} cst_t;

	function automatic cst_t cordic_iter(input cst_t c, input int i);
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] a;
		cst_t                 r;
		dx = c.y >>> i;
		dy = c.x >>> i;
		a  = $signed({{(CW-32){1'b0}}, atan_turn(5'(i))});
		r  = c;
		if (!c.z[CW-1]) begin
			r.x = c.x - dx;
			r.y = c.y + dy;
			r.z = c.z - a;
		end else begin
			r.x = c.x + dx;
			r.y = c.y - dy;
			r.z = c.z + a;
		end
		return r;
	endfunction

	logic       v_s   [NST];
	rope_side_t side_s[NST];
	logic       v_d   [NST];
	rope_side_t side_d[NST];
	cst_t       c_s   [NST];
	cst_t       c_d   [NST];

	// valid and side data chain
	assign v_d[0]    = v_in;
	assign side_d[0] = side_in;
	for (genvar g = 0; g < NST; g++) begin : g_chain
		if (g > 0) begin : g_link
			assign v_d[g]    = v_s[g-1];
			assign side_d[g] = side_s[g-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= v_d[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[g] <= side_d[g];
				c_s[g]    <= c_d[g];
			end
		end
	end

	// fold the phase into the right half plane
	always_comb begin
		c_d[0] = '{x: CORDIC_K_Q30, y: '0, z: CW'($signed(phase)), neg: 1'b0};
		if (c_d[0].z > QUARTER_TURN) begin
			c_d[0].z   = c_d[0].z - HALF_TURN;
			c_d[0].neg = 1'b1;
		end else if (c_d[0].z < -QUARTER_TURN) begin
			c_d[0].z   = c_d[0].z + HALF_TURN;
			c_d[0].neg = 1'b1;
		end
	end

	// two micro-rotations per stage, one in the last stage when the count is odd
	for (genvar g = 1; g <= IT_ST; g++) begin : g_iter
		localparam int I0 = 2 * (g - 1);
		localparam int I1 = I0 + 1;
		if (I1 < NIT) begin : g_two
			assign c_d[g] = cordic_iter(cordic_iter(c_s[g-1], I0), I1);
		end else begin : g_one
			assign c_d[g] = cordic_iter(c_s[g-1], I0);
		end
	end

	// undo the fold
	always_comb begin
		c_d[NST-1] = c_s[NST-2];
		if (c_s[NST-2].neg) begin
			c_d[NST-1].x = -c_s[NST-2].x;
			c_d[NST-1].y = -c_s[NST-2].y;
		end
	end

	assign v_out    = v_s[NST-1];
	assign side_out = side_s[NST-1];
	assign cos_val  = c_s[NST-1].x;
	assign sin_val  = c_s[NST-1].y;

endmodule

// File: rtl/core/rope_rotate.sv
module rope_rotate (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           v_in,
	input  logic signed [rope_pkg::CW-1:0] cos_val,
	input  logic signed [rope_pkg::CW-1:0] sin_val,
	input  rope_pkg::rope_side_t           side_in,
	output logic                           v_out,
	output rope_pkg::rope_out_t            res
);
	import rope_pkg::*;

	typedef struct packed {
		logic signed [65:0] qac;
		logic signed [65:0] qbs;
		logic signed [65:0] qas;
		logic signed [65:0] qbc;
		logic signed [65:0] kac;
		logic signed [65:0] kbs;
		logic signed [65:0] kas;
		logic signed [65:0] kbc;
	} prod_t;

	// round Q46 to Q16.16 and clamp to 32 bits
	function automatic logic signed [31:0] round_sat(input logic signed [65:0] p0,
			input logic signed [65:0] p1, input logic sub);
		logic signed [66:0] acc;
		logic signed [36:0] sh;
		logic signed [31:0] r;
		acc = sub ? (67'(p0) - 67'(p1)) : (67'(p0) + 67'(p1));
		acc = acc + 67'sd536870912;
		sh  = 37'(acc >>> 30);
		if (sh > 37'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (sh < -37'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = sh[31:0];
		end
		return r;
	endfunction

	prod_t      prod_s1;
	rope_side_t side_s1;
	logic       v_s1;
	rope_out_t  res_s2;
	logic       v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	// products for both pairs
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1     <= side_in;
			prod_s1.qac <= 66'(side_in.q_even) * 66'(cos_val);
			prod_s1.qbs <= 66'(side_in.q_odd) * 66'(sin_val);
			prod_s1.qas <= 66'(side_in.q_even) * 66'(sin_val);
			prod_s1.qbc <= 66'(side_in.q_odd) * 66'(cos_val);
			prod_s1.kac <= 66'(side_in.k_even) * 66'(cos_val);
			prod_s1.kbs <= 66'(side_in.k_odd) * 66'(sin_val);
			prod_s1.kas <= 66'(side_in.k_even) * 66'(sin_val);
			prod_s1.kbc <= 66'(side_in.k_odd) * 66'(cos_val);
		end
	end

	// combine, round and pick rotated or passed values
	always_ff @(posedge clk) begin
		if (en) begin
			if (side_s1.bypass) begin
				res_s2.q_even_out <= side_s1.q_even;
				res_s2.q_odd_out  <= side_s1.q_odd;
			end else begin
				res_s2.q_even_out <= round_sat(prod_s1.qac, prod_s1.qbs, 1'b1);
				res_s2.q_odd_out  <= round_sat(prod_s1.qas, prod_s1.qbc, 1'b0);
			end
			if (side_s1.rot_k) begin
				res_s2.k_even_out <= round_sat(prod_s1.kac, prod_s1.kbs, 1'b1);
				res_s2.k_odd_out  <= round_sat(prod_s1.kas, prod_s1.kbc, 1'b0);
			end else begin
				res_s2.k_even_out <= side_s1.k_even;
				res_s2.k_odd_out  <= side_s1.k_odd;
			end
			res_s2.key_rotated <= side_s1.rot_k;
		end
	end

	assign v_out = v_s2;
	assign res   = res_s2;

endmodule

// File: rtl/core/rotary_position_embedding.sv
// Throughput: one transaction per cycle; the modulo/ratio divider, exponent
// series and CORDIC are fully pipelined, so only the output stall holds items.
// The whole pipeline advances together whenever the output register is free.
// Reset clears all valid bits and loads head length 128, kv_dim 4096.
module rotary_position_embedding #(
	parameter int MAX_DIM       = 4096,
	parameter int CORDIC_STAGES = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	rope_in_if.sink     token,
	rope_out_if.source  result,
	rope_cfg_if.sink    cfg
);
	import rope_pkg::*;

	logic [9:0]  head_len_q;
	logic [12:0] kv_dim_q;

	// configuration writes
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_len_q <= HEAD_SIZE_RST;
			kv_dim_q   <= KV_DIM_RST;
		end else if (cfg.valid) begin
			if (cfg.data.index == REG_HEAD_SIZE) begin
				head_len_q <= cfg.data.value[9:0];
			end else if (cfg.data.index == REG_KV_DIM) begin
				kv_dim_q <= cfg.data.value;
			end
		end
	end

	// pipeline advance
	logic en;
	logic v_out;
	assign en          = !v_out || result.ready;
	assign token.ready = en;

	// element index and pass-through decisions
	logic [EW-1:0] elem;
	rope_side_t    side_in;
	assign elem = {token.data.pair_index, 1'b0};
	always_comb begin
		side_in.bypass = 32'(elem) >= 32'(MAX_DIM);
		side_in.rot_k  = !side_in.bypass && ({1'b0, elem} < kv_dim_q);
		side_in.q_even = token.data.q_even;
		side_in.q_odd  = token.data.q_odd;
		side_in.k_even = token.data.k_even;
		side_in.k_odd  = token.data.k_odd;
	end

	logic                 phase_v;
	logic [31:0]          phase;
	rope_side_t           side_ph;
	logic                 trig_v;
	logic signed [CW-1:0] cos_val;
	logic signed [CW-1:0] sin_val;
	rope_side_t           side_trig;

	rope_freq u_freq (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (token.valid),
		.position (token.data.position),
		.elem     (elem),
		.head_len (head_len_q),
		.side_in  (side_in),
		.v_out    (phase_v),
		.phase    (phase),
		.side_out (side_ph)
	);

	rope_cordic #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (phase_v),
		.phase    (phase),
		.side_in  (side_ph),
		.v_out    (trig_v),
		.cos_val  (cos_val),
		.sin_val  (sin_val),
		.side_out (side_trig)
	);

	rope_rotate u_rotate (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (trig_v),
		.cos_val (cos_val),
		.sin_val (sin_val),
		.side_in (side_trig),
		.v_out   (v_out),
		.res     (result.data)
	);

	assign result.valid = v_out;

`ifndef SYNTHESIS
	// a stall freezes the inner valid bits
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(phase_v) && $stable(trig_v)))
		else $error("pipeline moved during stall");

	// CORDIC outputs stay within one turn-circle of Q30 magnitude
	a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
		trig_v |-> (cos_val < CW'(64'sd1100000000) && cos_val > -CW'(64'sd1100000000)
			&& sin_val < CW'(64'sd1100000000) && sin_val > -CW'(64'sd1100000000)))
		else $error("cos/sin out of range");

	// a result only shows up after an advance
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(en))
		else $error("result appeared without advance");
`endif

endmodule
